/* hw/rtl/amt_pkg.sv */
// ----------------------------------------------------------------------------
// amt_pkg
// Shared types, constants and helpers for the affine matrix transform unit.
// ----------------------------------------------------------------------------
package amt_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
  localparam int ACC_WIDTH   = PROD_WIDTH + 4;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic signed [ACC_WIDTH-1:0]   acc_t;

  localparam val_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam val_t VAL_ONE = val_t'(64'sd1 <<< FRAC_BITS);

  typedef enum logic [2:0] {
    KIND_IDENTITY  = 3'd0,
    KIND_LOAD_ROW  = 3'd1,
    KIND_SRC_ROW   = 3'd2,
    KIND_TRANSLATE = 3'd3,
    KIND_INVERSE   = 3'd4,
    KIND_POINT     = 3'd5,
    KIND_READ_ROW  = 3'd6,
    KIND_UNUSED    = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TRANS,
    ST_INV,
    ST_POINT,
    ST_OUT
  } state_t;

  // saturate an exact sum to the value range
  function automatic val_t sat_val(input acc_t a, output logic ovf);
    ovf = 1'b0;
    sat_val = a[VALUE_WIDTH-1:0];
    if (a > acc_t'(VAL_MAX)) begin
      ovf = 1'b1;
      sat_val = VAL_MAX;
    end else if (a < acc_t'(VAL_MIN)) begin
      ovf = 1'b1;
      sat_val = VAL_MIN;
    end
  endfunction

endpackage

/* hw/rtl/amt_mac.sv */
// ----------------------------------------------------------------------------
// amt_mac
// Shared multiply-accumulate: one product a*b >>> FRAC_BITS per cycle,
// registered, then summed into a wide accumulator.
// ----------------------------------------------------------------------------
module amt_mac
  import amt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,      // load accumulator with init, drop pending product
  input  acc_t init,
  input  logic mul_en,
  input  val_t op_a,
  input  val_t op_b,
  output acc_t acc
);

  logic signed [PROD_WIDTH-1:0] prod_r;
  logic                         prod_v_r;
  acc_t                         acc_r;
  acc_t                         prod_q;

  assign prod_q = acc_t'(prod_r >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    prod_r <= PROD_WIDTH'(op_a) * PROD_WIDTH'(op_b);
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      prod_v_r <= mul_en & ~start;
      if (start) acc_r <= init;
      else if (prod_v_r) acc_r <= acc_r + prod_q;
    end
  end

  assign acc = acc_r;

endmodule

/* hw/rtl/affine_matrix_transform_unit.sv */
// ----------------------------------------------------------------------------
// affine_matrix_transform_unit
// 4x4 Q16.16 transform matrix with load, multiply, translate, rigid inverse,
// point transform and row readback.
// ----------------------------------------------------------------------------
// One shared 32x32 multiplier with a registered product feeds one accumulator
// under a small sequencer. Identity, row loads, source rows 0..2 and kind 7
// complete when accepted; read row holds the addressed row in the output
// register; translate adds the input vector to elements 0..2 of row 3;
// point transform forms three outputs of three products, then holds them in
// the output register; rigid inverse forms three terms of three products;
// the row 3 source multiply forms sixteen four-product elements by column.
// The input is not ready while an item is in progress or its result word
// waits in the output register.
// ----------------------------------------------------------------------------
module affine_matrix_transform_unit
  import amt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tuser,   // [2:0] kind, [4:3] row_index, zero pad
  input  logic [127:0] in_tdata,   // value_a, value_b, value_c, value_d
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // out_a, out_b, out_c, out_d
  output logic         out_tuser   // saturated
);

  state_t state_r, state_nxt;
  val_t   m_r [16];
  val_t   s_r [16];
  val_t   v_r [4];
  logic   sat_r;
  val_t   res_r [4];
  logic   out_sat_r;
  // staging: one product column for the multiply, two inverse translations
  val_t   col_r [3];
  val_t   inv_r [2];
  // element counter (i,j) and step counter k plus drain
  logic [1:0] ei_r, ej_r;
  logic [2:0] k_r;

  val_t   op_a, op_b;
  acc_t   init;
  logic   start, mul_en;
  acc_t   acc;
  val_t   sat_res;
  logic   ovf;
  val_t   neg_res;
  logic   neg_ovf;
  logic   elem_done;
  logic [1:0] kk;
  logic [2:0] kind;
  logic [1:0] row;
  val_t   vin [4];

  assign kind = in_tuser[2:0];
  assign row  = in_tuser[4:3];
  assign kk   = k_r[1:0];
  always_comb begin
    for (int i = 0; i < 4; i++) vin[i] = in_tdata[32*i +: 32];
  end

  amt_mac u_mac (
    .clk(clk), .rst_n(rst_n), .start(start), .init(init),
    .mul_en(mul_en), .op_a(op_a), .op_b(op_b), .acc(acc)
  );

  always_comb sat_res = sat_val(acc, ovf);
  always_comb neg_res = sat_val(-acc, neg_ovf);

  // step k: 0 = start, 1..N = multiply k-1, N+1 = drain, N+2 = write
  logic [2:0] n_prod;
  always_comb begin
    unique case (state_r)
      ST_MUL:  n_prod = 3'd4;
      ST_INV, ST_POINT: n_prod = 3'd3;
      default: n_prod = 3'd0;
    endcase
  end
  assign elem_done = (k_r == n_prod + 3'd2);

  // operand selection
  always_comb begin
    op_a = '0;
    op_b = '0;
    init = '0;
    unique case (state_r)
      ST_MUL: begin
        op_a = s_r[{ei_r, kk - 2'd1}];
        op_b = m_r[{kk - 2'd1, ej_r}];
      end
      ST_INV: begin
        op_a = m_r[{2'd3, kk - 2'd1}];
        op_b = m_r[{ei_r, kk - 2'd1}];
      end
      ST_POINT: begin
        op_a = m_r[{kk - 2'd1, ei_r}];
        op_b = v_r[kk - 2'd1];
        init = acc_t'(m_r[{2'd3, ei_r}]);
      end
      ST_TRANS: init = acc_t'(m_r[{2'd3, ei_r}]) + acc_t'(v_r[ei_r]);
      default: ;
    endcase
    start  = (k_r == 3'd0);
    mul_en = (k_r != 3'd0) && (k_r <= n_prod);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid && in_tready) begin
        unique case (kind)
          KIND_SRC_ROW:   if (row == 2'd3) state_nxt = ST_MUL;
          KIND_TRANSLATE: state_nxt = ST_TRANS;
          KIND_INVERSE:   state_nxt = ST_INV;
          KIND_POINT:     state_nxt = ST_POINT;
          KIND_READ_ROW:  state_nxt = ST_OUT;
          default: ;
        endcase
      end
      ST_MUL: if (elem_done && ei_r == 2'd3 && ej_r == 2'd3) state_nxt = ST_IDLE;
      ST_TRANS: if (k_r == 3'd2 && ei_r == 2'd2) state_nxt = ST_IDLE;
      ST_INV: if (elem_done && ei_r == 2'd2) state_nxt = ST_IDLE;
      ST_POINT: if (elem_done && ei_r == 2'd2) state_nxt = ST_OUT;
      ST_OUT: if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_OUT);
    for (int i = 0; i < 4; i++) out_tdata[32*i +: 32] = res_r[i];
    out_tuser = out_sat_r;
  end

  logic write_now;
  assign write_now = (state_r == ST_TRANS) ? (k_r == 3'd2) : elem_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      sat_r     <= 1'b0;
      ei_r      <= '0;
      ej_r      <= '0;
      k_r       <= '0;
      out_sat_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        m_r[i] <= (i % 5 == 0) ? VAL_ONE : '0;
        s_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) begin
        ei_r <= '0;
        ej_r <= '0;
        k_r  <= '0;
        if (in_tvalid) begin
          for (int i = 0; i < 4; i++) v_r[i] <= vin[i];
          unique case (kind)
            KIND_IDENTITY:
              for (int i = 0; i < 16; i++) m_r[i] <= (i % 5 == 0) ? VAL_ONE : '0;
            KIND_LOAD_ROW:
              for (int i = 0; i < 4; i++) m_r[{row, 2'(i)}] <= vin[i];
            KIND_SRC_ROW:
              for (int i = 0; i < 4; i++) s_r[{row, 2'(i)}] <= vin[i];
            KIND_READ_ROW: begin
              for (int i = 0; i < 4; i++) res_r[i] <= m_r[{row, 2'(i)}];
              out_sat_r <= sat_r;
              sat_r     <= 1'b0;
            end
            default: ;
          endcase
        end
      end else if (state_r != ST_OUT) begin
        if (write_now) begin
          k_r <= '0;
          unique case (state_r)
            ST_MUL: begin
              // column j of M is only read by column j, so it can be
              // replaced once all four of its elements are known
              if (ovf) sat_r <= 1'b1;
              if (ei_r == 2'd3) begin
                for (int i = 0; i < 3; i++) m_r[{2'(i), ej_r}] <= col_r[i];
                m_r[{2'd3, ej_r}] <= sat_res;
                ej_r <= ej_r + 2'd1;
              end else begin
                col_r[ei_r] <= sat_res;
              end
              ei_r <= ei_r + 2'd1;
            end
            ST_TRANS: begin
              if (ovf) sat_r <= 1'b1;
              m_r[{2'd3, ei_r}] <= sat_res;
              ei_r <= ei_r + 2'd1;
            end
            ST_INV: begin
              if (neg_ovf) sat_r <= 1'b1;
              ei_r <= ei_r + 2'd1;
              if (ei_r == 2'd2) begin
                for (int i = 0; i < 3; i++)
                  for (int j = 0; j < 3; j++)
                    m_r[{2'(i), 2'(j)}] <= m_r[{2'(j), 2'(i)}];
                m_r[12] <= inv_r[0];
                m_r[13] <= inv_r[1];
                m_r[14] <= neg_res;
              end else begin
                inv_r[ei_r[0]] <= neg_res;
              end
            end
            ST_POINT: begin
              res_r[ei_r] <= sat_res;
              res_r[3]    <= '0;
              ei_r <= ei_r + 2'd1;
              if (ei_r == 2'd2) begin
                out_sat_r <= sat_r | ovf;
                sat_r     <= 1'b0;
              end else if (ovf) begin
                sat_r <= 1'b1;
              end
            end
            default: ;
          endcase
        end else begin
          k_r <= k_r + 3'd1;
        end
      end
    end
  end

endmodule
